### rtl/core/lec_pkg.sv
// package for the letter escape codec
// constants, result job type, queue status type and character helpers; no dependencies
package lec_pkg;

	localparam int LINE_LENGTH = 80;
	localparam int MAX_RES     = 6;

	localparam logic [7:0] CH_Q  = 8'h51;
	localparam logic [7:0] CH_A  = 8'h61;
	localparam logic [7:0] CH_P  = 8'h70;
	localparam logic [7:0] CH_NL = 8'h0A;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] chars;
		logic                    err;
		logic [2:0]              cnt;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic is_alpha_char(input logic [7:0] c);
		is_alpha_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_nibble(input logic [7:0] c);
		is_nibble = (c >= CH_A) && (c <= CH_P);
	endfunction

endpackage

### rtl/core/lec_in_if.sv
// input channel of the letter escape codec
// valid/ready handshake carrying one byte or an end marker
interface lec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

### rtl/core/lec_out_if.sv
// result channel of the letter escape codec
// valid/ready handshake carrying one character or an error mark
interface lec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       error;
	logic       last;

	modport source (output valid, output out_byte, output error, output last, input ready);
	modport sink (input valid, input out_byte, input error, input last, output ready);
endinterface

### rtl/core/lec_cfg_if.sv
// configuration write channel of the letter escape codec
// valid/ready handshake carrying the mode register value
interface lec_cfg_if;
	logic valid;
	logic ready;
	logic mode;

	modport source (output valid, output mode, input ready);
	modport sink (input valid, input mode, output ready);
endinterface

### rtl/core/lec_front.sv
// front end: accepts items, keeps codec state, builds one result job per item
// depends on lec_pkg, lec_in_if, lec_cfg_if
module lec_front (
	input  logic            clk,
	input  logic            arst_n,
	lec_in_if.sink          src,
	lec_cfg_if.sink         cfg,
	input  lec_pkg::q_stat_t stat,
	output logic            push,
	output lec_pkg::job_t   job
);
	import lec_pkg::*;

	localparam logic [1:0] PH_PLAIN = 2'd0;
	localparam logic [1:0] PH_ESC   = 2'd1;
	localparam logic [1:0] PH_HIGH  = 2'd2;

	logic       mode_q;
	logic [6:0] line_count_q, line_count_d;
	logic       seen_q, seen_d;
	logic [1:0] phase_q, phase_d;
	logic [3:0] high_q, high_d;
	logic       failed_q, failed_d;

	logic [7:0] c;
	logic [7:0] ofs;
	logic [7:0] b [3];
	logic [1:0] nb;
	logic [6:0] lc;
	logic [2:0] k;
	logic       acc;

	assign src.ready = !stat.full;
	assign cfg.ready = 1'b1;
	assign acc       = src.valid && src.ready;
	assign c         = src.in_byte;
	assign ofs       = c - CH_A;
	assign push      = acc && (job.cnt != 3'd0);

	always_comb begin
		line_count_d = line_count_q;
		seen_d       = seen_q;
		phase_d      = phase_q;
		high_d       = high_q;
		failed_d     = failed_q;
		job          = '0;
		b[0]         = c;
		b[1]         = CH_Q;
		b[2]         = CH_A;
		nb           = 2'd1;
		lc           = line_count_q;
		k            = 3'd0;
		if (src.end_of_stream) begin
			if (mode_q == MODE_ENC) begin
				if (seen_q) begin
					job.chars[0] = CH_NL;
					job.cnt      = 3'd1;
				end
			end else if (!failed_q && phase_q != PH_PLAIN) begin
				job.err = 1'b1;
				job.cnt = 3'd1;
			end
			line_count_d = '0;
			seen_d       = 1'b0;
			phase_d      = PH_PLAIN;
			high_d       = '0;
			failed_d     = 1'b0;
		end else if (mode_q == MODE_ENC) begin
			seen_d = 1'b1;
			if (c == CH_Q) begin
				b[0] = CH_Q;
				nb   = 2'd2;
			end else if (!is_alpha_char(c)) begin
				b[0] = CH_Q;
				b[1] = CH_A + {4'd0, c[7:4]};
				b[2] = CH_A + {4'd0, c[3:0]};
				nb   = 2'd3;
			end
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < nb) begin
					job.chars[k] = b[i];
					k = k + 3'd1;
					lc = lc + 7'd1;
					if (lc == 7'(LINE_LENGTH)) begin
						job.chars[k] = CH_NL;
						k = k + 3'd1;
						lc = '0;
					end
				end
			end
			job.cnt      = k;
			line_count_d = lc;
		end else if (!failed_q && is_alpha_char(c)) begin
			unique case (phase_q)
				PH_PLAIN: begin
					if (c == CH_Q) begin
						phase_d = PH_ESC;
					end else begin
						job.chars[0] = c;
						job.cnt      = 3'd1;
					end
				end
				PH_ESC: begin
					if (c == CH_Q) begin
						job.chars[0] = CH_Q;
						job.cnt      = 3'd1;
						phase_d      = PH_PLAIN;
					end else if (is_nibble(c)) begin
						high_d  = ofs[3:0];
						phase_d = PH_HIGH;
					end else begin
						job.err  = 1'b1;
						job.cnt  = 3'd1;
						failed_d = 1'b1;
						phase_d  = PH_PLAIN;
					end
				end
				default: begin
					if (is_nibble(c)) begin
						job.chars[0] = {high_q, ofs[3:0]};
					end else begin
						job.err  = 1'b1;
						failed_d = 1'b1;
					end
					job.cnt = 3'd1;
					phase_d = PH_PLAIN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ENC;
			line_count_q <= '0;
			seen_q       <= 1'b0;
			phase_q      <= PH_PLAIN;
			high_q       <= '0;
			failed_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				mode_q <= cfg.mode;
			end
			if (acc) begin
				line_count_q <= line_count_d;
				seen_q       <= seen_d;
				phase_q      <= phase_d;
				high_q       <= high_d;
				failed_q     <= failed_d;
			end
		end
	end

endmodule

### rtl/core/lec_queue.sv
// two-entry job queue between front and back end
// depends on lec_pkg
module lec_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lec_pkg::job_t    push_job,
	input  logic             pop,
	output lec_pkg::job_t    head,
	output lec_pkg::q_stat_t stat,
	output logic [1:0]       count
);
	import lec_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign count      = count_q;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

### rtl/core/lec_back.sv
// back end: serializes queued jobs into one result transfer per cycle while snk.ready is high and jobs are queued
// depends on lec_pkg, lec_out_if
module lec_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lec_pkg::job_t    head,
	input  lec_pkg::q_stat_t stat,
	output logic             pop,
	lec_out_if.source        snk
);
	import lec_pkg::*;

	job_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_err_q;
	logic       out_last_q;
	logic       adv;
	logic       take;
	logic       cur_last;

	assign adv      = !out_valid_q || snk.ready;
	assign take     = adv && cur_valid_q;
	assign cur_last = (pos_q == cur_q.cnt - 3'd1);
	assign pop      = (!cur_valid_q || (take && cur_last)) && !stat.empty;

	assign snk.valid    = out_valid_q;
	assign snk.out_byte = out_byte_q;
	assign snk.error    = out_err_q;
	assign snk.last     = out_last_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= cur_q.chars[pos_q];
			out_err_q  <= cur_q.err;
			out_last_q <= cur_last;
		end
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= cur_valid_q;
			end
			if (take) begin
				pos_q <= pos_q + 3'd1;
				if (cur_last) begin
					cur_valid_q <= 1'b0;
				end
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= '0;
			end
		end
	end

endmodule

### rtl/core/letter_escape_codec.sv
// top level of the letter escape codec
// depends on lec_pkg, lec_*_if, lec_front, lec_queue, lec_back
//
// usage:
//   src carries bytes (in_byte) or an end marker (end_of_stream); a transfer
//   happens when valid and ready are high at a rising clock edge.
//   snk carries results: out_byte, error and last, which marks the final
//   result caused by one input item. items causing no result produce nothing.
//   cfg writes the mode bit (0 encode, 1 decode); write only while idle.
// timing:
//   an item passes the queue, the current job and output registers before
//   snk.valid rises. one result leaves per cycle while snk.ready is high and
//   a byte gives at most 4 results (three characters and a line break); the
//   front accepts one item per cycle while the queue has room.
// reset:
//   arst_n clears mode to encode, all codec state, queue and output.
// stalls:
//   when snk.ready is low the result holds; the queue fills and src.ready
//   drops once both queue entries are taken.
module letter_escape_codec (
	input  logic clk,
	input  logic arst_n,
	lec_in_if.sink    src,
	lec_out_if.source snk,
	lec_cfg_if.sink   cfg
);
	import lec_pkg::*;

	job_t       job;
	job_t       head;
	q_stat_t    stat;
	logic       push;
	logic       pop;
	logic [1:0] q_count;

	lec_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.cfg    (cfg),
		.stat   (stat),
		.push   (push),
		.job    (job)
	);

	lec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.stat     (stat),
		.count    (q_count)
	);

	lec_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.snk    (snk)
	);

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		snk.valid && snk.error |-> snk.out_byte == 8'd0 && snk.last)
		else $error("error result with data or without last");

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count != 2'd3)
		else $error("job queue count overflow");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!src.ready |-> stat.full)
		else $error("input stalled with queue room");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full && !pop |=> q_count == 2'd2)
		else $error("queue lost or gained a job while full");

endmodule

### test/tb.sv
// testbench for letter_escape_codec: encode and decode streams with random stalls
// scoreboard predicts results per accepted transfer and checks them in order
// depends on lec_pkg, lec_in_if, lec_out_if, lec_cfg_if and the codec rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lec_pkg::*;

	localparam int STALL_LIMIT = 400;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       err;
		logic       last;
	} result_t;

	typedef enum logic [1:0] {PH_PLAIN, PH_AFTER_Q, PH_AFTER_HIGH} phase_t;

	class escape_scoreboard;
		logic       mode;
		logic [6:0] line_count;
		logic       seen_input;
		phase_t     phase;
		logic [3:0] high_nibble;
		logic       failed;
		result_t    expected_q[$];
		result_t    batch[$];
		int         fails;
		int         checked;
		int         error_results;
		int         line_breaks;

		function new();
			mode = MODE_ENC;
			clear_stream();
			fails = 0;
			checked = 0;
			error_results = 0;
			line_breaks = 0;
		endfunction

		static function bit is_alpha(logic [7:0] c);
			logic [7:0] low;
			low = c | 8'h20;
			return low >= 8'h61 && low <= 8'h7A;
		endfunction

		function void clear_stream();
			line_count = '0;
			seen_input = 1'b0;
			phase = PH_PLAIN;
			high_nibble = '0;
			failed = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void put(logic [7:0] ch, logic err);
			result_t r;
			r.ch = ch;
			r.err = err;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function void put_counted(logic [7:0] ch);
			put(ch, 1'b0);
			line_count = line_count + 7'd1;
			if (line_count == LINE_LENGTH) begin
				put(CH_NL, 1'b0);
				line_count = '0;
			end
		endfunction

		function void decode_char(logic [7:0] b);
			logic [7:0] d;
			d = b - CH_A;
			if (failed || !is_alpha(b))
				return;
			case (phase)
				PH_PLAIN: begin
					if (b == CH_Q)
						phase = PH_AFTER_Q;
					else
						put(b, 1'b0);
				end
				PH_AFTER_Q: begin
					if (b == CH_Q) begin
						put(CH_Q, 1'b0);
						phase = PH_PLAIN;
					end else if (b >= CH_A && b <= CH_P) begin
						high_nibble = d[3:0];
						phase = PH_AFTER_HIGH;
					end else begin
						put(8'h00, 1'b1);
						failed = 1'b1;
						phase = PH_PLAIN;
					end
				end
				default: begin
					if (b >= CH_A && b <= CH_P) begin
						put({high_nibble, d[3:0]}, 1'b0);
					end else begin
						put(8'h00, 1'b1);
						failed = 1'b1;
					end
					phase = PH_PLAIN;
				end
			endcase
		endfunction

		function void note_input(logic [7:0] b, logic eos);
			batch.delete();
			if (eos) begin
				if (mode == MODE_ENC) begin
					if (seen_input)
						put(CH_NL, 1'b0);
				end else if (!failed && phase != PH_PLAIN) begin
					put(8'h00, 1'b1);
				end
				clear_stream();
			end else if (mode == MODE_ENC) begin
				seen_input = 1'b1;
				if (b == CH_Q) begin
					put_counted(CH_Q);
					put_counted(CH_Q);
				end else if (is_alpha(b)) begin
					put_counted(b);
				end else begin
					put_counted(CH_Q);
					put_counted(CH_A + b[7:4]);
					put_counted(CH_A + b[3:0]);
				end
			end else begin
				decode_char(b);
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				expected_q.push_back(batch[i]);
		endfunction

		function void check_result(logic [7:0] ch, logic err, logic last);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result out_byte=%h error=%b last=%b", ch, err, last);
				fails++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (err)
				error_results++;
			if (ch == CH_NL && !err)
				line_breaks++;
			if (ch !== e.ch) begin
				$error("out_byte: expected %h, got %h", e.ch, ch);
				fails++;
			end
			if (err !== e.err) begin
				$error("error: expected %b, got %b", e.err, err);
				fails++;
			end
			if (last !== e.last) begin
				$error("last: expected %b, got %b", e.last, last);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int   items_sent;
	int   mode_writes;
	int   src_idle_pct;
	int   idle_cycles;
	logic cur_mode;
	escape_scoreboard sb;

	lec_in_if  src_if();
	lec_out_if snk_if();
	lec_cfg_if cfg_if();

	letter_escape_codec uut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_if),
		.snk(snk_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_if.valid && src_if.ready)
				sb.note_input(src_if.in_byte, src_if.end_of_stream);
			if (snk_if.valid && snk_if.ready)
				sb.check_result(snk_if.out_byte, snk_if.error, snk_if.last);
			if (cfg_if.valid && cfg_if.ready) begin
				sb.mode = cfg_if.mode;
				mode_writes++;
			end
			if ((src_if.valid && src_if.ready) || (snk_if.valid && snk_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		snk_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				snk_if.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			snk_if.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	function automatic logic [7:0] rand_letter();
		int v;
		v = $urandom_range(0, 51);
		return 8'((v < 26) ? 8'h41 + v : 8'h61 + v - 26);
	endfunction

	function automatic logic [7:0] rand_non_letter();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (escape_scoreboard::is_alpha(b))
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic send_item(input logic [7:0] b, input logic eos);
		if (!quiet && src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			src_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		src_if.valid <= 1'b1;
		src_if.in_byte <= b;
		src_if.end_of_stream <= eos;
		@(posedge clk);
		while (!src_if.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		src_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_if.valid <= 1'b1;
		cfg_if.mode <= m;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		cur_mode = m;
	endtask

	task automatic send_escaped(input logic [7:0] b);
		if (b == CH_Q) begin
			send_item(CH_Q, 1'b0);
			send_item(CH_Q, 1'b0);
		end else if (escape_scoreboard::is_alpha(b)) begin
			send_item(b, 1'b0);
		end else begin
			send_item(CH_Q, 1'b0);
			send_item(CH_A + b[7:4], 1'b0);
			send_item(CH_A + b[3:0], 1'b0);
		end
	endtask

	task automatic random_stream(input logic m, input int len);
		int k;
		int pick;
		for (k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (m == MODE_ENC) begin
				if (pick < 35)
					send_item(rand_letter(), 1'b0);
				else if (pick < 50)
					send_item(CH_Q, 1'b0);
				else
					send_item(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				if (pick < 50) begin
					send_escaped(8'($urandom_range(0, 255)));
				end else if (pick < 75) begin
					send_escaped(rand_letter());
				end else if (pick < 87) begin
					send_item(8'($urandom_range(0, 255)), 1'b0);
				end else if (pick < 96) begin
					send_item(CH_NL, 1'b0);
				end else begin
					send_item(CH_Q, 1'b0);
					send_item(rand_letter(), 1'b0);
				end
			end
			if (!quiet && $urandom_range(0, 49) == 0)
				drain();
		end
	endtask

	task automatic fill_line();
		int chars_left;
		chars_left = LINE_LENGTH;
		while (chars_left > 0) begin
			if (chars_left >= 3 && $urandom_range(0, 2) != 0) begin
				send_item(rand_non_letter(), 1'b0);
				chars_left -= 3;
			end else if (chars_left >= 2 && $urandom_range(0, 1) == 0) begin
				send_item(CH_Q, 1'b0);
				chars_left -= 2;
			end else begin
				send_item(8'(8'h41 + $urandom_range(0, 15)), 1'b0);
				chars_left -= 1;
			end
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		int target;
		sb = new();
		quiet = 1'b0;
		items_sent = 0;
		mode_writes = 0;
		idle_cycles = 0;
		src_idle_pct = 30;
		cur_mode = MODE_ENC;
		src_if.valid <= 1'b0;
		src_if.in_byte <= 8'h00;
		src_if.end_of_stream <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.mode <= MODE_ENC;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(MODE_ENC);
		send_item("A", 1'b0);
		send_item("z", 1'b0);
		send_item(CH_Q, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h40, 1'b0);
		send_item(8'h5B, 1'b1);
		send_item(8'h00, 1'b1);
		drain();

		write_mode(MODE_DEC);
		send_item("Z", 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_Q, 1'b0);
		send_item(CH_Q, 1'b0);
		send_item(CH_Q, 1'b0);
		send_item("p", 1'b0);
		send_item("a", 1'b0);
		send_item(CH_Q, 1'b0);
		send_item("b", 1'b0);
		send_item(CH_Q, 1'b0);
		send_item("A", 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(CH_Q, 1'b0);
		send_item("z", 1'b0);
		send_item(8'h00, 1'b1);
		send_item(CH_Q, 1'b0);
		send_item(8'h00, 1'b1);
		drain();

		write_mode(MODE_ENC);
		src_idle_pct = 15;
		fill_line();

		target = 250;
		while (items_sent < target) begin
			if (items_sent + 40 > target)
				quiet = 1'b1;
			if (!quiet && $urandom_range(0, 2) == 0) begin
				drain();
				write_mode(1'($urandom_range(0, 1)));
			end
			case ($urandom_range(0, 2))
				0: src_idle_pct = 0;
				1: src_idle_pct = 15;
				default: src_idle_pct = 40;
			endcase
			random_stream(cur_mode, $urandom_range(1, 24));
			if ($urandom_range(0, 4) != 0)
				send_item(8'($urandom_range(0, 255)), 1'b1);
		end

		quiet = 1'b1;
		drain();
		$display("covered %0d input items and %0d mode writes in both modes",
			items_sent, mode_writes);
		$display("checked %0d results: %0d decode errors, %0d line breaks",
			sb.checked, sb.error_results, sb.line_breaks);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
